/* src/nqsc_pkg.sv */
// shared constants and types for the n-queens solution counter
`default_nettype none

package nqsc_pkg;

    // default largest board the search hardware supports
    localparam int MAX_BOARD_DEF = 16;

    // configuration port geometry
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // register field widths and result width
    localparam int FIELD_W = 5;
    localparam int COUNT_W = 32;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [FIELD_W-1:0]    t_field;
    typedef logic [COUNT_W-1:0]    t_count;

    // register indexes
    localparam t_cfg_idx REG_BOARD_SIZE    = 1'b0;
    localparam t_cfg_idx REG_QUEENS_WANTED = 1'b1;

    // reset values of the registers
    localparam t_field BOARD_SIZE_RST    = 5'd8;
    localparam t_field QUEENS_WANTED_RST = 5'd8;

    // saturation value of the solution count
    localparam t_count COUNT_MAX = '1;

endpackage

`default_nettype wire

/* src/nqsc_in_if.sv */
// start word channel of the n-queens solution counter
`default_nettype none

interface nqsc_in_if;
    logic valid;
    logic ready;
    logic start_search;

    modport source (output valid, output start_search, input ready);
    modport sink   (input valid, input start_search, output ready);
endinterface

`default_nettype wire

/* src/nqsc_out_if.sv */
// result word channel of the n-queens solution counter
`default_nettype none

interface nqsc_out_if;
    logic                 valid;
    logic                 ready;
    logic [31:0]          solution_count;
    logic                 count_saturated;

    modport source (output valid, output solution_count, output count_saturated, input ready);
    modport sink   (input valid, input solution_count, input count_saturated, output ready);
endinterface

`default_nettype wire

/* src/nqsc_marks.sv */
// column, diagonal and anti-diagonal occupancy masks with shared index unit
`default_nettype none

module nqsc_marks #(
    parameter int MAX_BOARD = nqsc_pkg::MAX_BOARD_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic [((MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1)-1:0] i_row,
    input  wire logic [$clog2(MAX_BOARD + 1)-1:0]       i_col,
    input  wire logic [$clog2(MAX_BOARD + 1)-1:0]       i_n,
    input  wire logic                                   i_toggle,
    output logic                                        o_free
);

    localparam int DMW = 2 * MAX_BOARD - 1;
    localparam int DW  = (DMW > 1) ? $clog2(DMW) : 1;

    logic [MAX_BOARD-1:0] r_cols;
    logic [DMW-1:0]       r_diag;
    logic [DMW-1:0]       r_anti;

    logic [DW-1:0]        diag_idx;
    logic [DW-1:0]        anti_idx;
    logic [MAX_BOARD-1:0] col_oh;
    logic [DMW-1:0]       diag_oh;
    logic [DMW-1:0]       anti_oh;

    // square indexes: diagonal is row + n - 1 - col, anti-diagonal row + col
    assign diag_idx = DW'(int'(i_row) + int'(i_n) - 1 - int'(i_col));
    assign anti_idx = DW'(int'(i_row) + int'(i_col));

    // one-hot selects; an index past the end of a mask shifts out to zero
    assign col_oh  = MAX_BOARD'(1) << i_col;
    assign diag_oh = DMW'(1) << diag_idx;
    assign anti_oh = DMW'(1) << anti_idx;

    // square is free when none of its three lines is taken
    assign o_free = ((r_cols & col_oh) == '0) && ((r_diag & diag_oh) == '0)
                    && ((r_anti & anti_oh) == '0);

    // place or lift a queen by toggling its three marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= '0;
            r_diag <= '0;
            r_anti <= '0;
        end else if (i_toggle) begin
            r_cols <= r_cols ^ col_oh;
            r_diag <= r_diag ^ diag_oh;
            r_anti <= r_anti ^ anti_oh;
        end
    end

    // every placed queen holds exactly one mark in each mask
    a_diag_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_cols) == $countones(r_diag))
        else $error("column and diagonal mark counts differ");

    a_anti_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_cols) == $countones(r_anti))
        else $error("column and anti-diagonal mark counts differ");

    // a toggle always lands on a real column
    a_toggle_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_toggle |-> (int'(i_col) < int'(i_n)))
        else $error("mark toggle outside the board");

endmodule

`default_nettype wire

/* src/nqsc_col_stack.sv */
// stack of placed column per row
`default_nettype none

module nqsc_col_stack #(
    parameter int MAX_BOARD = nqsc_pkg::MAX_BOARD_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1)-1:0] i_waddr,
    input  wire logic [$clog2(MAX_BOARD + 1)-1:0]       i_wdata,
    input  wire logic [((MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1)-1:0] i_raddr,
    output logic [$clog2(MAX_BOARD + 1)-1:0]            o_rdata
);

    localparam int CW = $clog2(MAX_BOARD + 1);

    logic [CW-1:0] r_cols [MAX_BOARD];
    logic [CW-1:0] r_rdata;

    // push the column of a newly placed row
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_cols[i_waddr] <= i_wdata;
        end
    end

    // registered read for the next cycle, a push to the same row passes straight through
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_cols[i_raddr];
        end
    end

    // column of the row being lifted on backtrack
    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/nqsc_seq.sv */
// search sequencer: depth-first placement, solution count and result register
`default_nettype none

module nqsc_seq #(
    parameter int MAX_BOARD = nqsc_pkg::MAX_BOARD_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // start word
    input  wire logic                                   i_req_valid,
    input  wire logic                                   i_start_search,
    output logic                                        o_req_ready,
    // configuration
    input  wire logic [$clog2(MAX_BOARD + 1)-1:0]       i_n,
    input  wire nqsc_pkg::t_field                       i_q,
    // mark unit
    output logic [((MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1)-1:0] o_mk_row,
    output logic [$clog2(MAX_BOARD + 1)-1:0]            o_mk_col,
    output logic                                        o_mk_toggle,
    input  wire logic                                   i_mk_free,
    // column stack
    output logic                                        o_st_we,
    output logic [((MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1)-1:0] o_st_waddr,
    output logic [$clog2(MAX_BOARD + 1)-1:0]            o_st_wdata,
    output logic [((MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1)-1:0] o_st_raddr,
    input  wire logic [$clog2(MAX_BOARD + 1)-1:0]       i_st_rdata,
    // result word
    output logic                                        o_res_valid,
    input  wire logic                                   i_res_ready,
    output nqsc_pkg::t_count                            o_count,
    output logic                                        o_saturated
);

    localparam int RW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
    localparam int CW = $clog2(MAX_BOARD + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [RW-1:0]    r_row, n_row;
    logic [CW-1:0]    r_col, n_col;
    nqsc_pkg::t_count r_total, n_total;
    logic             r_out_valid;
    nqsc_pkg::t_count r_out_count;
    logic             r_out_sat;

    logic             accept;
    logic             col_end;
    logic             last_row;
    logic             out_free;
    logic             load_out;

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign col_end     = int'(r_col) >= int'(i_n);
    assign last_row    = (int'(r_row) + 1) == int'(i_q);
    assign out_free    = !r_out_valid || i_res_ready;
    assign load_out    = (r_state == ST_DONE) && out_free;

    // stack is pushed at the current row; the read addresses the row above the next row
    assign o_st_waddr = r_row;
    assign o_st_wdata = r_col;
    assign o_st_raddr = n_row - RW'(1);

    // one search step per cycle
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_total     = r_total;
        o_mk_row    = r_row;
        o_mk_col    = r_col;
        o_mk_toggle = 1'b0;
        o_st_we     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_row = '0;
                    n_col = '0;
                    if (!i_start_search) begin
                        n_state = ST_DONE;
                    end else if (i_q == '0) begin
                        n_total = nqsc_pkg::t_count'(1);
                        n_state = ST_DONE;
                    end else if (int'(i_q) > int'(i_n)) begin
                        n_total = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_total = '0;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (col_end) begin
                    if (r_row == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        // backtrack: lift the queen of the row above
                        o_mk_row    = r_row - RW'(1);
                        o_mk_col    = i_st_rdata;
                        o_mk_toggle = 1'b1;
                        n_row       = r_row - RW'(1);
                        n_col       = i_st_rdata + CW'(1);
                    end
                end else if (i_mk_free) begin
                    if (last_row) begin
                        if (r_total != nqsc_pkg::COUNT_MAX) begin
                            n_total = r_total + nqsc_pkg::t_count'(1);
                        end
                        n_col = r_col + CW'(1);
                    end else begin
                        // place and descend
                        o_mk_toggle = 1'b1;
                        o_st_we     = 1'b1;
                        n_row       = r_row + RW'(1);
                        n_col       = '0;
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_total <= n_total;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_count <= r_total;
            r_out_sat   <= (r_total == nqsc_pkg::COUNT_MAX);
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_count     = r_out_count;
    assign o_saturated = r_out_sat;

    // the search never descends past the last wanted row
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (int'(r_row) < int'(i_q)))
        else $error("search row beyond wanted queens");

    // exhausting row zero ends the search
    a_search_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && col_end && r_row == '0) |=> (r_state == ST_DONE))
        else $error("search did not finish after row zero exhausted");

    // count only grows while searching
    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && $past(r_state == ST_RUN)) |-> (r_total >= $past(r_total)))
        else $error("solution count decreased during search");

    // flag agrees with the count it is sent with
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_sat == (r_out_count == nqsc_pkg::COUNT_MAX)))
        else $error("saturation flag disagrees with count");

endmodule

`default_nettype wire

/* src/n_queens_solution_counter.sv */
// n-queens solution counter top level: config registers and search core
//
// Usage: a word on i_req with start_search set runs a full depth-first
// n-queens search on the board_size and queens_wanted registers; one result
// word (solution_count, count_saturated) leaves on o_rsp for every request.
// A request with start_search clear returns the count of the last search.
// Registers are written on i_cfg_we (index 0 board_size, 1 queens_wanted);
// the user must write them only while no request is in flight, which the
// block itself does not enforce; the next search picks them up. Steps: the
// request is taken in the idle state, the search tries one column or makes
// one backtrack per step in the search tree, and the count then moves into
// the output register. The single mark unit checks or toggles one square a
// cycle. i_req.ready is high only while no search is running.
// A result word waiting on o_rsp does not block the next request; a finished
// search then holds until the output register is free.
// Reset clears all masks, the count and the output valid and loads the
// registers with eight; it needs no clearing pass.
`default_nettype none

module n_queens_solution_counter #(
    parameter int MAX_BOARD = nqsc_pkg::MAX_BOARD_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    nqsc_in_if.sink                  i_req,
    nqsc_out_if.source               o_rsp,
    input  wire logic                i_cfg_we,
    input  wire nqsc_pkg::t_cfg_idx  i_cfg_idx,
    input  wire nqsc_pkg::t_cfg_data i_cfg_data
);

    localparam int RW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
    localparam int CW = $clog2(MAX_BOARD + 1);

    nqsc_pkg::t_field r_board_size;
    nqsc_pkg::t_field r_queens_wanted;
    logic [CW-1:0]    n_eff;

    logic [RW-1:0]    mk_row;
    logic [CW-1:0]    mk_col;
    logic             mk_toggle;
    logic             mk_free;
    logic             st_we;
    logic [RW-1:0]    st_waddr;
    logic [CW-1:0]    st_wdata;
    logic [RW-1:0]    st_raddr;
    logic [CW-1:0]    st_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size    <= nqsc_pkg::BOARD_SIZE_RST;
            r_queens_wanted <= nqsc_pkg::QUEENS_WANTED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nqsc_pkg::REG_BOARD_SIZE:    r_board_size    <= i_cfg_data;
                nqsc_pkg::REG_QUEENS_WANTED: r_queens_wanted <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // board size limited to what the masks hold
    assign n_eff = (int'(r_board_size) > MAX_BOARD) ? CW'(MAX_BOARD) : CW'(r_board_size);

    nqsc_seq #(
        .MAX_BOARD (MAX_BOARD)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req.valid),
        .i_start_search (i_req.start_search),
        .o_req_ready    (i_req.ready),
        .i_n            (n_eff),
        .i_q            (r_queens_wanted),
        .o_mk_row       (mk_row),
        .o_mk_col       (mk_col),
        .o_mk_toggle    (mk_toggle),
        .i_mk_free      (mk_free),
        .o_st_we        (st_we),
        .o_st_waddr     (st_waddr),
        .o_st_wdata     (st_wdata),
        .o_st_raddr     (st_raddr),
        .i_st_rdata     (st_rdata),
        .o_res_valid    (o_rsp.valid),
        .i_res_ready    (o_rsp.ready),
        .o_count        (o_rsp.solution_count),
        .o_saturated    (o_rsp.count_saturated)
    );

    nqsc_marks #(
        .MAX_BOARD (MAX_BOARD)
    ) u_marks (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_row    (mk_row),
        .i_col    (mk_col),
        .i_n      (n_eff),
        .i_toggle (mk_toggle),
        .o_free   (mk_free)
    );

    nqsc_col_stack #(
        .MAX_BOARD (MAX_BOARD)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

endmodule

`default_nettype wire
